// ===== design/ctp_pkg.sv =====
// Shared definitions for the circle tangent point pipeline.
// Holds parameter defaults, register indexes and the branch class type.
// No dependencies.
package ctp_pkg;

  localparam int CTP_COORD_WIDTH = 32;
  localparam int CTP_FRAC_BITS   = 16;
  localparam int CTP_ADDR_W      = 3;

  // register index, taken from paddr[2]
  localparam logic REG_FALLBACK_X = 1'b0;
  localparam logic REG_FALLBACK_Y = 1'b1;

  // which formula an item goes through
  typedef enum logic [1:0] {
    CLS_OUTSIDE,
    CLS_NEAR,
    CLS_RADIAL
  } cls_t;

endpackage

// ===== design/circle_tangent_point.sv =====
// Circle tangent point: fully pipelined fixed point tangent, radial projection or fallback point.
// Depends on ctp_pkg (defaults, register indexes, cls_t).
//
// Channel  Dir  Contents (lowest bits first)
// s_axis   in   tdata: point_x, point_y, center_x, center_y, radius, clockwise
// m_axis   out  tdata: tangent_x, tangent_y; tuser: inside_circle
// apb      in   fallback_dir_x at 0x0, fallback_dir_y at 0x4 (read and write)
//
// One item per cycle while the output is not stalled.
// The depth comes from the bit-per-stage square root (twice) and the
// bit-per-stage divider, one quotient or root bit in each register stage.
// Reset clears the valid bits and sets the fallback direction to (0, 1.0).
// While the output item waits and m_axis_tready is low, every stage holds.
module circle_tangent_point
  import ctp_pkg::*;
#(
  parameter int COORD_WIDTH = CTP_COORD_WIDTH,
  parameter int FRAC_BITS   = CTP_FRAC_BITS,
  localparam int IN_TW      = ((5 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW     = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x, point_y, center_x, center_y, radius, clockwise
  input  logic [IN_TW-1:0]      s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tangent_x, tangent_y
  output logic [OUT_TW-1:0]     m_axis_tdata,
  // inside_circle
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CTP_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int SQW = 2 * W;
  localparam int D2W = 2 * W + 1;
  localparam int R2W = 2 * W - 2;
  localparam int K1  = W + 2;
  localparam int HW  = W + 1;
  localparam int AW  = 2 * W - 1;
  localparam int BW  = 2 * W + 1;
  localparam int TW  = 2 * W + 2;
  localparam int NW  = 4 * W;
  localparam int QW  = 2 * W;
  localparam int K2  = W;
  localparam int OW  = W + 1;
  localparam int FW  = FRAC_BITS + 2;
  localparam int NFW = W - 1 + FW;
  localparam int PLW = 2 * W - 1;
  localparam int PHW = 2 * W + 1;

  localparam longint unsigned NEAR_L = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
  localparam logic [D2W-1:0] NEAR_SQ = D2W'(NEAR_L);
  localparam logic [D2W-1:0] ONE_FX  = D2W'(1) << FRAC_BITS;

  localparam int V_S3  = K1 + 3;
  localparam int V_S6  = K1 + 6;
  localparam int V_S7  = V_S6 + QW + 1;
  localparam int V_OUT = V_S7 + K2 + 1;
  localparam int NST   = V_OUT + 1;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic [W-2:0]        r;
    logic [W-1:0]        mx;
    logic [W-1:0]        my;
    logic                nx;
    logic                ny;
    logic                cw;
    logic                sx;
    logic                sy;
    cls_t                cls;
    logic [D2W-1:0]      d2;
  } ctx_t;

  function automatic logic [W-1:0] place(input logic signed [W-1:0] c,
                                         input logic [OW-1:0] mag, input logic neg);
    logic signed [W+1:0] m;
    logic signed [W+1:0] s;
    m = $signed((W + 2)'(mag));
    s = (W + 2)'(c) + (neg ? -m : m);
    if (s > $signed({3'b000, {(W - 1){1'b1}}})) begin
      s = $signed({3'b000, {(W - 1){1'b1}}});
    end else if (s < $signed({3'b111, {(W - 1){1'b0}}})) begin
      s = $signed({3'b111, {(W - 1){1'b0}}});
    end
    return W'(s);
  endfunction

  logic           adv;
  logic [NST-1:0] vld;
  logic [FW-1:0]  fb_x;
  logic [FW-1:0]  fb_y;

  assign adv           = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[V_OUT];
  assign pready        = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_x <= '0;
      fb_y <= {2'b01, {FRAC_BITS{1'b0}}};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FALLBACK_X: fb_x <= pwdata[FW-1:0];
        REG_FALLBACK_Y: fb_y <= pwdata[FW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FALLBACK_X: prdata = 32'(fb_x);
      REG_FALLBACK_Y: prdata = 32'(fb_y);
    endcase
  end

  // stage 0: differences
  logic signed [W-1:0]  in_px, in_py, in_cx, in_cy;
  logic signed [DW-1:0] s0_dx, s0_dy;
  logic signed [W-1:0]  s0_cx, s0_cy;
  logic [W-2:0]         s0_r;
  logic                 s0_cw;

  assign in_px = $signed(s_axis_tdata[W-1:0]);
  assign in_py = $signed(s_axis_tdata[2*W-1:W]);
  assign in_cx = $signed(s_axis_tdata[3*W-1:2*W]);
  assign in_cy = $signed(s_axis_tdata[4*W-1:3*W]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx <= DW'(in_px) - DW'(in_cx);
      s0_dy <= DW'(in_py) - DW'(in_cy);
      s0_cx <= in_cx;
      s0_cy <= in_cy;
      s0_r  <= s_axis_tdata[5*W-2:4*W];
      s0_cw <= s_axis_tdata[5*W-1];
    end
  end

  // stage 1: magnitudes and squares
  ctx_t           c1_n, ctx1;
  logic [SQW-1:0] s1_m2x, s1_m2y;
  logic [R2W-1:0] s1_r2;

  always_comb begin
    c1_n     = '0;
    c1_n.cx  = s0_cx;
    c1_n.cy  = s0_cy;
    c1_n.r   = s0_r;
    c1_n.cw  = s0_cw;
    c1_n.nx  = s0_dx[DW-1];
    c1_n.ny  = s0_dy[DW-1];
    c1_n.mx  = W'(s0_dx[DW-1] ? -s0_dx : s0_dx);
    c1_n.my  = W'(s0_dy[DW-1] ? -s0_dy : s0_dy);
    c1_n.cls = CLS_RADIAL;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1   <= c1_n;
      s1_m2x <= c1_n.mx * c1_n.mx;
      s1_m2y <= c1_n.my * c1_n.my;
      s1_r2  <= c1_n.r * c1_n.r;
    end
  end

  // stage 2: classify, feed the first square root with 4*(D2-R2)
  logic [D2W-1:0]  s2_d2, s2_e;
  logic            s2_out;
  ctx_t            c2_n;
  logic [2*K1-1:0] sq1_x    [0:K1];
  logic [K1+1:0]   sq1_rem  [0:K1];
  logic [K1-1:0]   sq1_root [0:K1];
  ctx_t            sq1_ctx  [0:K1];

  always_comb begin
    s2_d2   = D2W'(s1_m2x) + D2W'(s1_m2y);
    s2_out  = s2_d2 > D2W'(s1_r2);
    s2_e    = s2_d2 - D2W'(s1_r2);
    c2_n    = ctx1;
    c2_n.d2 = s2_d2;
    priority if (s2_out) begin
      c2_n.cls = CLS_OUTSIDE;
    end else if (s2_d2 <= NEAR_SQ) begin
      c2_n.cls = CLS_NEAR;
    end else begin
      c2_n.cls = CLS_RADIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_x[0]    <= s2_out ? (2 * K1)'({s2_e, 2'b00}) : '0;
      sq1_rem[0]  <= '0;
      sq1_root[0] <= '0;
      sq1_ctx[0]  <= c2_n;
    end
  end

  for (genvar j = 1; j <= K1; j++) begin : g_sq1
    logic [K1+3:0] sh;
    logic [K1+3:0] tr;
    logic          ge;
    always_comb begin
      sh = {sq1_rem[j-1], sq1_x[j-1][2*K1-1 -: 2]};
      tr = (K1 + 4)'({sq1_root[j-1], 2'b01});
      ge = sh >= tr;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_x[j]    <= sq1_x[j-1] << 2;
        sq1_rem[j]  <= ge ? (K1 + 2)'(sh - tr) : (K1 + 2)'(sh);
        sq1_root[j] <= {sq1_root[j-1][K1-2:0], ge};
        sq1_ctx[j]  <= sq1_ctx[j-1];
      end
    end
  end

  // stage 3: h and the first products
  logic [HW-1:0] s3_h;
  ctx_t          ctx3;
  logic [AW-1:0] s3_ax, s3_ay;
  logic [BW-1:0] s3_bx, s3_by;

  assign s3_h = HW'(({1'b0, sq1_root[K1]} + (K1 + 1)'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3  <= sq1_ctx[K1];
      s3_ax <= sq1_ctx[K1].r * sq1_ctx[K1].mx;
      s3_ay <= sq1_ctx[K1].r * sq1_ctx[K1].my;
      s3_bx <= s3_h * sq1_ctx[K1].mx;
      s3_by <= s3_h * sq1_ctx[K1].my;
    end
  end

  // stage 4: signed tangent sums, partial squares, fallback products
  logic signed [TW:0] ax_e, ay_e, bx_e, by_e, tx_s, ty_s;
  logic [TW-1:0]      tx_m, ty_m;
  logic [FW-1:0]      fx_m, fy_m;
  ctx_t               c4_n, ctx4;
  logic [TW-1:0]      s4_txm, s4_tym;
  logic [2*W-1:0]     s4_llx, s4_lly;
  logic [2*W-2:0]     s4_hlx, s4_hly;
  logic [2*W-3:0]     s4_hhx, s4_hhy;
  logic [NFW-1:0]     s4_nfx, s4_nfy;

  always_comb begin
    ax_e = $signed((TW + 1)'(s3_ax));
    ay_e = $signed((TW + 1)'(s3_ay));
    bx_e = $signed((TW + 1)'(s3_bx));
    by_e = $signed((TW + 1)'(s3_by));
    tx_s = (ctx3.nx ? -ax_e : ax_e) + ((ctx3.ny ^ ctx3.cw) ? -by_e : by_e);
    ty_s = (ctx3.ny ? -ay_e : ay_e) + ((ctx3.nx ^ ~ctx3.cw) ? -bx_e : bx_e);
    tx_m = TW'(tx_s[TW] ? -tx_s : tx_s);
    ty_m = TW'(ty_s[TW] ? -ty_s : ty_s);
    fx_m = fb_x[FW-1] ? -fb_x : fb_x;
    fy_m = fb_y[FW-1] ? -fb_y : fb_y;
    c4_n = ctx3;
    unique case (ctx3.cls)
      CLS_OUTSIDE: begin
        c4_n.sx = tx_s[TW];
        c4_n.sy = ty_s[TW];
      end
      CLS_NEAR: begin
        c4_n.sx = fb_x[FW-1];
        c4_n.sy = fb_y[FW-1];
      end
      default: begin
        c4_n.sx = ctx3.nx;
        c4_n.sy = ctx3.ny;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4   <= c4_n;
      s4_txm <= tx_m;
      s4_tym <= ty_m;
      s4_llx <= s3_ax[W-1:0] * s3_ax[W-1:0];
      s4_lly <= s3_ay[W-1:0] * s3_ay[W-1:0];
      s4_hlx <= s3_ax[AW-1:W] * s3_ax[W-1:0];
      s4_hly <= s3_ay[AW-1:W] * s3_ay[W-1:0];
      s4_hhx <= s3_ax[AW-1:W] * s3_ax[AW-1:W];
      s4_hhy <= s3_ay[AW-1:W] * s3_ay[AW-1:W];
      s4_nfx <= ctx3.r * fx_m;
      s4_nfy <= ctx3.r * fy_m;
    end
  end

  // stage 5: r*|t| halves, radial numerator 4*(r*m)^2
  ctx_t           ctx5;
  logic [PLW-1:0] s5_pxl, s5_pyl;
  logic [PHW-1:0] s5_pxh, s5_pyh;
  logic [NW-1:0]  s5_rnx, s5_rny;
  logic [NFW-1:0] s5_nfx, s5_nfy;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx5   <= ctx4;
      s5_pxl <= ctx4.r * s4_txm[W-1:0];
      s5_pyl <= ctx4.r * s4_tym[W-1:0];
      s5_pxh <= ctx4.r * s4_txm[TW-1:W];
      s5_pyh <= ctx4.r * s4_tym[TW-1:W];
      s5_rnx <= ((NW'(s4_hhx) << (2 * W)) + (NW'(s4_hlx) << (W + 1)) + NW'(s4_llx)) << 2;
      s5_rny <= ((NW'(s4_hhy) << (2 * W)) + (NW'(s4_hly) << (W + 1)) + NW'(s4_lly)) << 2;
      s5_nfx <= s4_nfx;
      s5_nfy <= s4_nfy;
    end
  end

  // stage 6: pick numerator and divisor, feed the dividers
  logic [NW-1:0]  numx, numy;
  logic [D2W-1:0] den;
  logic [D2W-1:0] dvx_rem [0:QW];
  logic [D2W-1:0] dvy_rem [0:QW];
  logic [QW-1:0]  dvx_nb  [0:QW];
  logic [QW-1:0]  dvy_nb  [0:QW];
  logic [D2W-1:0] dv_den  [0:QW];
  ctx_t           dv_ctx  [0:QW];

  always_comb begin
    unique case (ctx5.cls)
      CLS_OUTSIDE: begin
        numx = (NW'(s5_pxh) << W) + NW'(s5_pxl);
        numy = (NW'(s5_pyh) << W) + NW'(s5_pyl);
        den  = ctx5.d2;
      end
      CLS_NEAR: begin
        numx = NW'(s5_nfx);
        numy = NW'(s5_nfy);
        den  = ONE_FX;
      end
      default: begin
        numx = s5_rnx;
        numy = s5_rny;
        den  = ctx5.d2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvx_rem[0] <= D2W'(numx[NW-1:QW]);
      dvy_rem[0] <= D2W'(numy[NW-1:QW]);
      dvx_nb[0]  <= numx[QW-1:0];
      dvy_nb[0]  <= numy[QW-1:0];
      dv_den[0]  <= den;
      dv_ctx[0]  <= ctx5;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [D2W:0] shx, shy, dn;
    logic         gex, gey;
    always_comb begin
      dn  = {1'b0, dv_den[j-1]};
      shx = {dvx_rem[j-1], dvx_nb[j-1][QW-1]};
      shy = {dvy_rem[j-1], dvy_nb[j-1][QW-1]};
      gex = shx >= dn;
      gey = shy >= dn;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dvx_rem[j] <= gex ? D2W'(shx - dn) : D2W'(shx);
        dvy_rem[j] <= gey ? D2W'(shy - dn) : D2W'(shy);
        dvx_nb[j]  <= {dvx_nb[j-1][QW-2:0], gex};
        dvy_nb[j]  <= {dvy_nb[j-1][QW-2:0], gey};
        dv_den[j]  <= dv_den[j-1];
        dv_ctx[j]  <= dv_ctx[j-1];
      end
    end
  end

  // stage 7: round the quotient, or feed the second square root
  logic            rad7, incx, incy;
  logic [2*K2-1:0] sq2x_x    [0:K2];
  logic [2*K2-1:0] sq2y_x    [0:K2];
  logic [K2+1:0]   sq2x_rem  [0:K2];
  logic [K2+1:0]   sq2y_rem  [0:K2];
  logic [K2-1:0]   sq2x_root [0:K2];
  logic [K2-1:0]   sq2y_root [0:K2];
  logic [OW-1:0]   sq2_mgx   [0:K2];
  logic [OW-1:0]   sq2_mgy   [0:K2];
  ctx_t            sq2_ctx   [0:K2];

  always_comb begin
    rad7 = dv_ctx[QW].cls == CLS_RADIAL;
    incx = {dvx_rem[QW], 1'b0} >= {1'b0, dv_den[QW]};
    incy = {dvy_rem[QW], 1'b0} >= {1'b0, dv_den[QW]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2x_x[0]    <= rad7 ? dvx_nb[QW] : '0;
      sq2y_x[0]    <= rad7 ? dvy_nb[QW] : '0;
      sq2x_rem[0]  <= '0;
      sq2y_rem[0]  <= '0;
      sq2x_root[0] <= '0;
      sq2y_root[0] <= '0;
      sq2_mgx[0]   <= OW'(dvx_nb[QW]) + OW'(incx);
      sq2_mgy[0]   <= OW'(dvy_nb[QW]) + OW'(incy);
      sq2_ctx[0]   <= dv_ctx[QW];
    end
  end

  for (genvar j = 1; j <= K2; j++) begin : g_sq2
    logic [K2+3:0] shx, shy, trx, try_v;
    logic          gex, gey;
    always_comb begin
      shx   = {sq2x_rem[j-1], sq2x_x[j-1][2*K2-1 -: 2]};
      shy   = {sq2y_rem[j-1], sq2y_x[j-1][2*K2-1 -: 2]};
      trx   = (K2 + 4)'({sq2x_root[j-1], 2'b01});
      try_v = (K2 + 4)'({sq2y_root[j-1], 2'b01});
      gex   = shx >= trx;
      gey   = shy >= try_v;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq2x_x[j]    <= sq2x_x[j-1] << 2;
        sq2y_x[j]    <= sq2y_x[j-1] << 2;
        sq2x_rem[j]  <= gex ? (K2 + 2)'(shx - trx) : (K2 + 2)'(shx);
        sq2y_rem[j]  <= gey ? (K2 + 2)'(shy - try_v) : (K2 + 2)'(shy);
        sq2x_root[j] <= {sq2x_root[j-1][K2-2:0], gex};
        sq2y_root[j] <= {sq2y_root[j-1][K2-2:0], gey};
        sq2_mgx[j]   <= sq2_mgx[j-1];
        sq2_mgy[j]   <= sq2_mgy[j-1];
        sq2_ctx[j]   <= sq2_ctx[j-1];
      end
    end
  end

  // output stage: final magnitude, add to center, saturate
  logic          rad_o;
  logic [OW-1:0] magx, magy;
  logic [W-1:0]  out_tx, out_ty;
  logic          out_in;

  always_comb begin
    rad_o = sq2_ctx[K2].cls == CLS_RADIAL;
    magx  = rad_o ? OW'(({1'b0, sq2x_root[K2]} + (K2 + 1)'(1)) >> 1) : sq2_mgx[K2];
    magy  = rad_o ? OW'(({1'b0, sq2y_root[K2]} + (K2 + 1)'(1)) >> 1) : sq2_mgy[K2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tx <= place(sq2_ctx[K2].cx, magx, sq2_ctx[K2].sx);
      out_ty <= place(sq2_ctx[K2].cy, magy, sq2_ctx[K2].sy);
      out_in <= sq2_ctx[K2].cls != CLS_OUTSIDE;
    end
  end

  assign m_axis_tdata = OUT_TW'({out_ty, out_tx});
  assign m_axis_tuser = out_in;

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[V_S7-1] |-> (dvx_rem[QW] < dv_den[QW]) && (dvy_rem[QW] < dv_den[QW]))
    else $error("divider remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[V_S3-1] |-> sq1_rem[K1] <= {sq1_root[K1], 1'b0})
    else $error("square root remainder out of range");

endmodule

// ===== verif/circle_tangent_point_checker.sv =====
`timescale 1ns / 100ps
// Checker for circle_tangent_point: tracks the fallback registers over APB, predicts
// every accepted item in fixed point and compares results in order.
// Depends on ctp_pkg (cls_t, register indexes).
module circle_tangent_point_checker
  import ctp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fails,
  output int           outstanding,
  output int           n_outside,
  output int           n_near,
  output int           n_radial
);

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic        in_circle;
  } tangent_t;

  typedef logic [191:0] wide_t;

  tangent_t    tangent_q[$];
  logic [17:0] fb_x = 18'h00000;
  logic [17:0] fb_y = 18'h10000;

  function automatic wide_t isqrt(input wide_t n);
    wide_t res, c;
    res = '0;
    for (int i = 95; i >= 0; i--) begin
      c = res | (wide_t'(1) << i);
      if (c * c <= n) res = c;
    end
    return res;
  endfunction

  function automatic wide_t div_round(input wide_t n, input wide_t d);
    wide_t q, rm;
    q  = n / d;
    rm = n % d;
    if (2 * rm >= d) q = q + 1;
    return q;
  endfunction

  // signed sum of two magnitudes
  function automatic wide_t mag_add(input wide_t a, input bit sa, input wide_t b,
                                    input bit sb, output bit so);
    if (sa == sb) begin
      so = sa;
      return a + b;
    end
    if (a >= b) begin
      so = sa;
      return a - b;
    end
    so = sb;
    return b - a;
  endfunction

  function automatic logic [31:0] place(input longint c, input wide_t mag, input bit neg);
    logic signed [127:0] s;
    s = neg ? (128'(c) - $signed({1'b0, mag[126:0]})) : (128'(c) + $signed({1'b0, mag[126:0]}));
    if (s > 128'sd2147483647) s = 128'sd2147483647;
    if (s < -128'sd2147483648) s = -128'sd2147483648;
    return s[31:0];
  endfunction

  function automatic tangent_t tangent_of(input logic [159:0] d, input logic [17:0] fx_raw,
                                          input logic [17:0] fy_raw, output cls_t cls);
    longint cx, cy, dx, dy, fx, fy;
    bit nx, ny, cw, sx, sy;
    wide_t mx, my, r, dx2, dy2, d2, r2, h, tx, ty, ox, oy;
    tangent_t t;
    cx = longint'($signed(d[95:64]));
    cy = longint'($signed(d[127:96]));
    dx = longint'($signed(d[31:0])) - cx;
    dy = longint'($signed(d[63:32])) - cy;
    r  = wide_t'(d[158:128]);
    cw = d[159];
    nx = dx < 0;
    ny = dy < 0;
    mx = wide_t'(nx ? -dx : dx);
    my = wide_t'(ny ? -dy : dy);
    dx2 = mx * mx;
    dy2 = my * my;
    d2  = dx2 + dy2;
    r2  = r * r;
    if (d2 > r2) begin
      cls = CLS_OUTSIDE;
      h  = (isqrt(4 * (d2 - r2)) + 1) >> 1;
      tx = mag_add(r * mx, nx, h * my, ny ^ cw, sx);
      ty = mag_add(r * my, ny, h * mx, nx ^ !cw, sy);
      ox = div_round(r * tx, d2);
      oy = div_round(r * ty, d2);
      t.in_circle = 1'b0;
    end else if (d2 <= 42) begin
      // distance below 0.0001: use the programmed fallback direction
      cls = CLS_NEAR;
      fx = longint'($signed(fx_raw));
      fy = longint'($signed(fy_raw));
      sx = fx < 0;
      sy = fy < 0;
      ox = div_round(r * wide_t'(sx ? -fx : fx), 192'd65536);
      oy = div_round(r * wide_t'(sy ? -fy : fy), 192'd65536);
      t.in_circle = 1'b1;
    end else begin
      cls = CLS_RADIAL;
      ox = (isqrt((4 * r2 * dx2) / d2) + 1) >> 1;
      oy = (isqrt((4 * r2 * dy2) / d2) + 1) >> 1;
      sx = nx;
      sy = ny;
      t.in_circle = 1'b1;
    end
    t.tx = place(cx, ox, sx);
    t.ty = place(cy, oy, sy);
    return t;
  endfunction

  initial begin
    fails = 0;
    n_outside = 0;
    n_near = 0;
    n_radial = 0;
  end

  assign outstanding = tangent_q.size();

  always @(posedge clk) begin
    tangent_t exp_t, got;
    cls_t     cls;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FALLBACK_X) fb_x <= pwdata[17:0];
        else fb_y <= pwdata[17:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_t = tangent_of(s_axis_tdata, fb_x, fb_y, cls);
        tangent_q.push_back(exp_t);
        case (cls)
          CLS_OUTSIDE: n_outside++;
          CLS_NEAR:    n_near++;
          default:     n_radial++;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx = m_axis_tdata[31:0];
        got.ty = m_axis_tdata[63:32];
        got.in_circle = m_axis_tuser;
        if (tangent_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected item: x=%h y=%h inside=%b",
                                    got.tx, got.ty, got.in_circle);
        end else begin
          exp_t = tangent_q.pop_front();
          if (got !== exp_t) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected x=%h y=%h inside=%b, got x=%h y=%h inside=%b",
                       exp_t.tx, exp_t.ty, exp_t.in_circle, got.tx, got.ty, got.in_circle);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_circle_tangent_point.sv =====
`timescale 1ns / 100ps
// Testbench top for circle_tangent_point: clock, reset, APB programming and stream stimulus.
// Depends on ctp_pkg, circle_tangent_point and circle_tangent_point_checker.
module tb_circle_tangent_point
  import ctp_pkg::*;
;

  localparam int LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // point_x, point_y, center_x, center_y, radius, clockwise
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tangent_x, tangent_y
  logic [63:0]  m_axis_tdata;
  // inside_circle
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int fails, outstanding, n_outside, n_near, n_radial;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int sent = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  always #2 clk = ~clk;

  circle_tangent_point dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  circle_tangent_point_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fails(fails), .outstanding(outstanding),
    .n_outside(n_outside), .n_near(n_near), .n_radial(n_radial)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [159:0] pack_query(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] cx, input logic [31:0] cy,
                                              input logic [30:0] r, input bit cw);
    return {cw, r, cy, cx, py, px};
  endfunction

  function automatic logic [31:0] near_off(input logic [31:0] base, input int lim);
    return base + 32'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  function automatic logic [159:0] random_query();
    logic [31:0] cx, cy, px, py;
    logic [30:0] r;
    int sel;
    sel = $urandom_range(9);
    cx = $urandom;
    cy = $urandom;
    r  = 31'($urandom >> $urandom_range(20, 1));
    if (sel == 8) begin
      // ordinary scale geometry
      cx = 32'($signed($urandom_range(2097152)) - 1048576);
      cy = 32'($signed($urandom_range(2097152)) - 1048576);
      r  = 31'($urandom_range(1048576));
    end
    px = $urandom;
    py = $urandom;
    case (sel)
      4: begin
        r  = 31'($urandom);
        px = near_off(cx, int'(r >> 3));
        py = near_off(cy, int'(r >> 3));
      end
      5: begin
        px = near_off(cx, 4);
        py = near_off(cy, 4);
        if ($urandom_range(1)) py = cy;
      end
      6: begin
        r  = 31'($urandom_range(1 << 24));
        px = cx + 32'(r);
        py = cy;
      end
      7: r = '0;
      8: begin
        px = near_off(cx, 3 * int'(r) + 16);
        py = near_off(cy, 3 * int'(r) + 16);
      end
      default: ;
    endcase
    return pack_query(px, py, cx, cy, r, 1'($urandom));
  endfunction

  task automatic send(input logic [159:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_fallback(input logic [31:0] fx, input logic [31:0] fy);
    apb_write({REG_FALLBACK_X, 2'b00}, fx);
    apb_write({REG_FALLBACK_Y, 2'b00}, fy);
  endtask

  logic [31:0] fb_x_set[6] = '{32'h0, -32'sd65536, 32'd65536, 32'h1ffff, 32'h20000, 32'd46341};
  logic [31:0] fb_y_set[6] = '{32'd65536, 32'h0, -32'sd65536, 32'h20000, 32'h1ffff, 32'd46341};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corner geometry under reset fallback (x=0, y=1.0)
    send_idle = 6;
    recv_idle = 75;
    send(pack_query(0, 0, 0, 0, 0, 0));
    send(pack_query(0, 0, 0, 0, 31'h10000, 0));
    send(pack_query(3, -32'sd4, 0, 0, 31'h10000, 1));
    send(pack_query(4, 5, 0, 0, 31'h10000, 0));
    send(pack_query(32'h30000, 32'h40000, 0, 0, 31'h10000, 0));
    send(pack_query(32'h30000, 32'h40000, 0, 0, 31'h10000, 1));
    send(pack_query(32'h10000, 0, 0, 0, 31'h10000, 0));
    send(pack_query(32'h8000, -32'sd8000, 0, 0, 31'h10000, 1));
    send(pack_query(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0));
    send(pack_query(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1));
    send(pack_query(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'h1, 1));
    send(pack_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0));
    send(pack_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 0));
    send(pack_query(0, 0, 32'h7fff0000, 32'h7fff0000, 31'h7fffffff, 0));
    send(pack_query(32'h12345678, 32'h9abcdef0, 32'h7ffffff0, 32'h80000010, 31'h0, 1));
    send(pack_query(32'h7fffffff, 0, 32'h7ffffffe, 0, 31'h7fffffff, 0));
    send(pack_query(32'hffff0000, 32'h00010000, 0, 0, 31'h00020000, 1));
    send(pack_query(32'h00050000, 0, 0, 0, 31'h00030000, 0));
    send(pack_query(32'h00050000, 0, 0, 0, 31'h00030000, 1));
    send(pack_query(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa, 1));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_fallback(fb_x_set[ph], fb_y_set[ph]);
      send_idle = (ph < 2) ? 6 : (ph < 4) ? 75 : 0;
      recv_idle = (ph < 2) ? 75 : (ph < 4) ? 6 : 0;
      // long receiver hold-off while items keep coming: pipeline fills and backs up
      if (ph == 4) hold_req <= 1'b1;
      // near-center queries in every phase exercise the new fallback
      send(pack_query(32'h100, 32'h200, 32'h100, 32'h200, 31'h7fffffff, 0));
      send(pack_query(32'h101, 32'h1fe, 32'h100, 32'h200, 31'h00018000, 1));
      for (int k = 0; k < 310; k++) send(random_query());
      if (ph == 2) begin
        drain();
        for (int k = 0; k < 20; k++) send(random_query());
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("%0d items: %0d outside tangents, %0d near-center fallbacks, %0d radial projections",
             sent, n_outside, n_near, n_radial);
    $display("six fallback settings, mixed stalls on both sides, long output hold-off");
    if (fails == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ctp_pkg.sv
design/circle_tangent_point.sv
verif/circle_tangent_point_checker.sv
verif/tb_circle_tangent_point.sv
